/* hdl/ufp_pkg.sv */
// Shared types and constants of the UBX frame filter parser.
`timescale 1ns / 1ps

package ufp_pkg;

    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    localparam logic [7:0]  WANTED_CLASS_RST = 8'h01;
    localparam logic [7:0]  WANTED_ID_RST    = 8'h07;
    localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_WANTED_CLASS = 2'd0,
        REG_WANTED_ID    = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_CK_ERROR = 3'd2,
        KIND_SKIPPED  = 3'd3,
        KIND_TOO_LONG = 3'd4
    } t_kind;

    typedef enum logic [8:0] {
        PH_HUNT1   = 9'b000000001,
        PH_HUNT2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  wanted_class;
        logic [7:0]  wanted_id;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] payload_length;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
        logic        last;
    } t_result;

endpackage

/* hdl/ufp_cfg.sv */
// APB configuration registers of the UBX frame filter parser.
`timescale 1ns / 1ps

module ufp_cfg import ufp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wanted_class <= WANTED_CLASS_RST;
            r_cfg.wanted_id    <= WANTED_ID_RST;
            r_cfg.max_payload  <= MAX_PAYLOAD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WANTED_CLASS: r_cfg.wanted_class <= pwdata[7:0];
                REG_WANTED_ID:    r_cfg.wanted_id    <= pwdata[7:0];
                REG_MAX_PAYLOAD:  r_cfg.max_payload  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WANTED_CLASS: prdata = {24'd0, r_cfg.wanted_class};
            REG_WANTED_ID:    prdata = {24'd0, r_cfg.wanted_id};
            REG_MAX_PAYLOAD:  prdata = {16'd0, r_cfg.max_payload};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/ufp_parser.sv */
// Frame state machine, Fletcher sums and result formation.
`timescale 1ns / 1ps

module ufp_parser import ufp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_ck_a, n_ck_a;

    logic        w_add;
    logic [7:0]  w_base_a, w_base_b;
    logic [7:0]  w_add_a, w_add_b;
    logic        w_wanted;
    logic [15:0] w_count_inc;
    logic [15:0] w_rx_ck, w_calc_ck;
    logic        w_emit;
    t_result     w_res;

    assign w_wanted    = (r_class == i_cfg.wanted_class) && (r_id == i_cfg.wanted_id);
    assign w_count_inc = r_count + 16'd1;
    assign w_rx_ck     = {i_rx_byte, r_ck_a};
    assign w_calc_ck   = {r_sum_b, r_sum_a};

    // class byte restarts the sums
    assign w_base_a = (r_phase == PH_CLASS) ? 8'd0 : r_sum_a;
    assign w_base_b = (r_phase == PH_CLASS) ? 8'd0 : r_sum_b;
    assign w_add_a  = w_base_a + i_rx_byte;
    assign w_add_b  = w_base_b + w_add_a;

    always_comb begin
        n_phase  = r_phase;
        n_class  = r_class;
        n_id     = r_id;
        n_length = r_length;
        n_count  = r_count;
        n_ck_a   = r_ck_a;
        w_add    = 1'b0;
        w_emit   = 1'b0;

        w_res.kind              = KIND_PAYLOAD;
        w_res.data_byte         = 8'd0;
        w_res.byte_index        = 16'd0;
        w_res.received_checksum = 16'd0;
        w_res.computed_checksum = 16'd0;
        w_res.last              = 1'b1;

        unique case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == SYNC_TWO) begin
                    n_phase = PH_CLASS;
                end else if (i_rx_byte != SYNC_ONE) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                w_add   = 1'b1;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                w_add   = 1'b1;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {8'd0, i_rx_byte};
                w_add    = 1'b1;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {i_rx_byte, r_length[7:0]};
                w_add    = 1'b1;
                n_count  = 16'd0;
                if (n_length > i_cfg.max_payload) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_TOO_LONG;
                    n_phase    = PH_HUNT1;
                end else if (n_length == 16'd0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w_add   = 1'b1;
                n_count = w_count_inc;
                if (w_wanted) begin
                    w_emit           = 1'b1;
                    w_res.data_byte  = i_rx_byte;
                    w_res.byte_index = r_count;
                    w_res.last       = 1'b0;
                end
                if (w_count_inc == r_length) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                n_ck_a  = i_rx_byte;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                w_emit                  = 1'b1;
                w_res.received_checksum = w_rx_ck;
                w_res.computed_checksum = w_calc_ck;
                if (!w_wanted) begin
                    w_res.kind = KIND_SKIPPED;
                end else if (w_rx_ck == w_calc_ck) begin
                    w_res.kind = KIND_GOOD;
                end else begin
                    w_res.kind = KIND_CK_ERROR;
                end
                n_phase = PH_HUNT1;
            end
            default: begin
                // hunting, and any stray phase code
                n_phase = (i_rx_byte == SYNC_ONE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase

        n_sum_a = w_add ? w_add_a : r_sum_a;
        n_sum_b = w_add ? w_add_b : r_sum_b;

        w_res.frame_class    = n_class;
        w_res.frame_id       = n_id;
        w_res.payload_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_sum_a  <= 8'd0;
            r_sum_b  <= 8'd0;
            r_class  <= 8'd0;
            r_id     <= 8'd0;
            r_length <= 16'd0;
            r_count  <= 16'd0;
            r_ck_a   <= 8'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_class  <= n_class;
            r_id     <= n_id;
            r_length <= n_length;
            r_count  <= n_count;
            r_ck_a   <= n_ck_a;
        end
    end

    assign o_res_valid = i_accept && w_emit;
    assign o_res       = w_res;

`ifndef SYNTHESIS
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PAYLOAD) |-> (r_phase == PH_PAYLOAD))
        else $error("payload beat outside payload phase");

    a_ckb_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_CK_B) |=> (r_phase == PH_HUNT1))
        else $error("frame end did not return to hunting");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_LEN_HI && n_length > i_cfg.max_payload)
        |-> (o_res_valid && o_res.kind == KIND_TOO_LONG))
        else $error("oversize length without abort status");

    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_PAYLOAD && w_count_inc == r_length)
        |=> (r_phase == PH_CK_A))
        else $error("payload end missed");
`endif

endmodule

/* hdl/ufp_out_buf.sv */
// Result register with a skid stage toward the output channel.
`timescale 1ns / 1ps

module ufp_out_buf import ufp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    w_slot_free;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_space     = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            // hold the beat until the output slot drains
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (!w_slot_free && i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full while output empty");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res_valid)
        else $error("result arrived with skid full");
`endif

endmodule

/* hdl/ubx_frame_filter_parser_core.sv */
// Top level: UBX frame filter parser with APB configuration.
// Output: a result is registered, via the skid stage if the output stalls.
// Throughput: one byte per cycle; the result register and one skid stage let
// a byte be taken while a result waits, ready drops only when both are full.
// Reset: synchronous, active low; hunting for sync, sums and header cleared,
// registers return to class 0x01, id 0x07, max payload 1024.
`timescale 1ns / 1ps

module ubx_frame_filter_parser_core import ufp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_data_byte,
    output logic [15:0]       o_byte_index,
    output logic [7:0]        o_frame_class,
    output logic [7:0]        o_frame_id,
    output logic [15:0]       o_payload_length,
    output logic [15:0]       o_received_checksum,
    output logic [15:0]       o_computed_checksum,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    logic    w_accept;
    logic    w_res_valid;
    t_result w_res, w_out;

    assign w_accept = i_rx_valid && o_rx_ready;

    ufp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ufp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ufp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_space     (o_rx_ready),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (w_out)
    );

    assign o_kind              = w_out.kind;
    assign o_data_byte         = w_out.data_byte;
    assign o_byte_index        = w_out.byte_index;
    assign o_frame_class       = w_out.frame_class;
    assign o_frame_id          = w_out.frame_id;
    assign o_payload_length    = w_out.payload_length;
    assign o_received_checksum = w_out.received_checksum;
    assign o_computed_checksum = w_out.computed_checksum;
    assign o_last              = w_out.last;

endmodule
